// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  // Geometry of the video memory and of the visible screen
  localparam int unsigned VRAM_WORDS  = 8192;
  localparam int unsigned SCREEN_COLS = 80;
  localparam int unsigned SCREEN_ROWS = 25;

  localparam int unsigned AW      = $clog2(VRAM_WORDS);
  localparam int unsigned COL_W   = $clog2(SCREEN_COLS);
  localparam int unsigned ROW_W   = $clog2(SCREEN_ROWS);
  localparam int unsigned PORT_AW = 13;

  localparam int unsigned BODY_WORDS   = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int unsigned SCROLL_SPAN  = SCREEN_COLS * (SCREEN_ROWS + 1);

  // Cell values
  localparam logic [15:0] BLANK_CELL   = 16'h0700;
  localparam logic [15:0] NEW_ROW_CELL = 16'h0C00;
  localparam logic [7:0]  ATTR_RESET   = 8'd14;

  // Control characters
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_LF,
    OP_CR,
    OP_BS,
    OP_READ
  } tcw_op_e;

  typedef struct packed {
    tcw_op_e              kind;
    logic [7:0]           code;
    logic [PORT_AW-1:0]   addr;
  } tcw_op_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_COPY_RD,
    BK_COPY_WR,
    BK_FILL,
    BK_DONE
  } tcw_bk_state_e;

  // Resize a memory word address to the port width
  function automatic logic [PORT_AW-1:0] to_port(input logic [AW-1:0] a);
    return PORT_AW'(a);
  endfunction

endpackage

// ===== rtl/tcw_front.sv =====
`timescale 1ns / 1ps

module tcw_front import tcw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [7:0]         char_code_i,
  input  logic [PORT_AW-1:0] read_addr_i,
  input  logic               clear_busy_i,
  output logic               push_valid_o,
  output tcw_op_t            push_item_o,
  input  logic               push_full_i
);

  logic    valid_q, valid_d;
  tcw_op_t op_q, op_d;
  logic    accept;
  logic    push;
  tcw_op_e kind;

  // Classify the incoming beat
  always_comb begin
    if (action_i) begin
      kind = OP_READ;
    end else if (char_code_i == CH_LF) begin
      kind = OP_LF;
    end else if (char_code_i == CH_CR) begin
      kind = OP_CR;
    end else if (char_code_i == CH_BS) begin
      kind = OP_BS;
    end else begin
      kind = OP_PRINT;
    end
  end

  assign push       = valid_q && !push_full_i;
  assign in_stall_o = clear_busy_i || (valid_q && push_full_i);
  assign accept     = in_valid_i && !in_stall_o;

  // Load a new beat, or drop the held one once it is queued
  always_comb begin
    valid_d = valid_q;
    op_d    = op_q;
    if (accept) begin
      valid_d      = 1'b1;
      op_d.kind    = kind;
      op_d.code    = char_code_i;
      op_d.addr    = read_addr_i;
    end else if (push) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = op_q;

endmodule

// ===== rtl/tcw_queue.sv =====
`timescale 1ns / 1ps

module tcw_queue import tcw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  input  tcw_op_t push_item_i,
  output logic    full_o,
  output logic    pop_valid_o,
  output tcw_op_t pop_item_o,
  input  logic    pop_i
);

  tcw_op_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;
  logic                push;
  logic                pop;

  assign full_o      = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid_o = count_q != '0;
  assign pop_item_o  = entry_q[rd_ptr_q];
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_i && pop_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/tcw_back.sv =====
`timescale 1ns / 1ps

module tcw_back import tcw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  tcw_op_t            q_item_i,
  output logic               q_pop_o,
  output logic               clear_busy_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        read_data_o,
  output logic [PORT_AW-1:0] cursor_word_o,
  output logic [PORT_AW-1:0] origin_word_o
);

  localparam logic [AW-1:0]    COLS_W   = AW'(SCREEN_COLS);
  localparam logic [AW-1:0]    BODY_W   = AW'(BODY_WORDS);
  localparam logic [AW-1:0]    LAST_W   = AW'(VRAM_WORDS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_COLS - 1);

  // Video memory
  logic [15:0]   mem [VRAM_WORDS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   rdata_q;

  tcw_bk_state_e state_q, state_d;
  logic [AW-1:0]    origin_q, origin_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [7:0]       attr_q;
  logic             is_read_q, is_read_d;

  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_data_q, out_data_d;
  logic [PORT_AW-1:0] out_cursor_q, out_cursor_d;
  logic [PORT_AW-1:0] out_origin_q, out_origin_d;

  logic             out_free;
  logic             take;
  logic             row_last;
  logic             col_last;
  logic             scroll_req;
  logic             scroll_fits;
  logic [AW-1:0]    row_base;
  logic [COL_W-1:0] col_sel;
  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    cur_pos;
  logic [AW-1:0]    copy_src;
  logic [AW-1:0]    fill_addr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = (state_q == BK_IDLE) && q_valid_i && out_free;
  assign row_last = row_q == ROW_LAST;
  assign col_last = col_q == COL_LAST;

  assign scroll_req = row_last &&
                      ((q_item_i.kind == OP_LF) || ((q_item_i.kind == OP_PRINT) && col_last));
  assign scroll_fits = ({1'b0, origin_q} + (AW + 1)'(SCROLL_SPAN)) <= (AW + 1)'(VRAM_WORDS - 1);

  // Cursor addressing
  assign row_base  = AW'(row_q) * COLS_W;
  assign col_sel   = (q_item_i.kind == OP_BS) ? col_q - 1'b1 : col_q;
  assign cur_addr  = origin_q + row_base + AW'(col_sel);
  assign cur_pos   = origin_q + row_base + AW'(col_q);
  assign copy_src  = origin_q + COLS_W + cnt_q;
  assign fill_addr = origin_q + BODY_W + cnt_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: begin
        if (cnt_q == LAST_W) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (take) begin
          if (scroll_req) begin
            state_d = scroll_fits ? BK_FILL : BK_COPY_RD;
          end else begin
            state_d = BK_DONE;
          end
        end
      end
      BK_COPY_RD: begin
        state_d = BK_COPY_WR;
      end
      BK_COPY_WR: begin
        state_d = (cnt_q == BODY_W - 1'b1) ? BK_FILL : BK_COPY_RD;
      end
      BK_FILL: begin
        if (cnt_q == COLS_W - 1'b1) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = cnt_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = cnt_q;
    origin_d     = origin_q;
    row_d        = row_q;
    col_d        = col_q;
    cnt_d        = cnt_q;
    is_read_d    = is_read_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_cursor_d = out_cursor_q;
    out_origin_d = out_origin_q;
    unique case (state_q)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = (cnt_q < BODY_W) ? BLANK_CELL : 16'h0000;
        cnt_d     = cnt_q + 1'b1;
      end
      BK_IDLE: begin
        if (take) begin
          is_read_d = q_item_i.kind == OP_READ;
          cnt_d     = '0;
          unique case (q_item_i.kind)
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = AW'(q_item_i.addr);
            end
            OP_LF: begin
              if (!row_last) begin
                row_d = row_q + 1'b1;
              end
            end
            OP_CR: begin
              col_d = '0;
            end
            OP_BS: begin
              if (col_q != '0) begin
                col_d     = col_sel;
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = BLANK_CELL;
              end
            end
            OP_PRINT: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {attr_q, q_item_i.code};
              if (col_last) begin
                col_d = '0;
                if (!row_last) begin
                  row_d = row_q + 1'b1;
                end
              end else begin
                col_d = col_q + 1'b1;
              end
            end
          endcase
          if (scroll_req && scroll_fits) begin
            origin_d = origin_q + COLS_W;
          end
        end
      end
      BK_COPY_RD: begin
        mem_re    = 1'b1;
        mem_raddr = copy_src;
      end
      BK_COPY_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = rdata_q;
        if (cnt_q == BODY_W - 1'b1) begin
          cnt_d    = '0;
          origin_d = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      BK_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr;
        mem_wdata = NEW_ROW_CELL;
        cnt_d     = cnt_q + 1'b1;
      end
      BK_DONE: begin
        out_valid_d  = 1'b1;
        out_data_d   = is_read_q ? rdata_q : 16'h0000;
        out_cursor_d = to_port(cur_pos);
        out_origin_d = to_port(origin_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      origin_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      attr_q      <= ATTR_RESET;
      is_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      origin_q    <= origin_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      is_read_q   <= is_read_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_cursor_q <= out_cursor_d;
    out_origin_q <= out_origin_d;
  end

  // Video memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign q_pop_o       = take;
  assign clear_busy_o  = state_q == BK_CLEAR;
  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_data_q;
  assign cursor_word_o = out_cursor_q;
  assign origin_word_o = out_origin_q;

endmodule

// ===== rtl/text_console_writer.sv =====
`timescale 1ns / 1ps

// Text console engine with its own 8192-word video memory. Each input beat
// prints one character (return, line feed and backspace handled) or reads
// one memory word, and yields one result beat with the read data and the
// cursor and display origin in words. A front stage classifies beats into a
// two-entry queue, so input keeps flowing while the engine works or a result
// waits, until the queue and the front stage are full. The engine owns the
// single-port-write, registered-read memory; a scroll also writes the new
// bottom row, and a scroll that wraps the origin to the start of memory
// first copies the 1920 words of the lower rows there (one read and one
// write per word). After reset the engine runs a clearing pass through all
// 8192 memory words, during which no input beat is taken; attribute writes
// are taken at any time.
module text_console_writer import tcw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [7:0]         char_code_i,
  input  logic [PORT_AW-1:0] read_addr_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        read_data_o,
  output logic [PORT_AW-1:0] cursor_word_o,
  output logic [PORT_AW-1:0] origin_word_o
);

  logic    clear_busy;
  logic    push_valid;
  tcw_op_t push_item;
  logic    q_full;
  logic    q_valid;
  tcw_op_t q_item;
  logic    q_pop;

  tcw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .read_addr_i  (read_addr_i),
    .clear_busy_i (clear_busy),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_full_i  (q_full)
  );

  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .full_o       (q_full),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_i        (q_pop)
  );

  tcw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .clear_busy_o  (clear_busy),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .cursor_word_o (cursor_word_o),
    .origin_word_o (origin_word_o)
  );

endmodule
